FILE: sv/ualt_pkg.sv
// Package for the identifier access list table: sizes, request codes and
// the structs that pass between the sequencer and the top level.
// Depends on nothing.
`timescale 1ns / 1ps
package ualt_pkg;

  localparam int CAPACITY = 16;
  localparam int UID_W    = 32;
  localparam int IDX_W    = 4;
  localparam int CNT_W    = 5;
  localparam int ACT_W    = 2;

  localparam logic [ACT_W-1:0] ACT_SEARCH = 2'd0;
  localparam logic [ACT_W-1:0] ACT_ADD    = 2'd1;
  localparam logic [ACT_W-1:0] ACT_DELETE = 2'd2;
  localparam logic [ACT_W-1:0] ACT_READ   = 2'd3;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [UID_W-1:0] uid;
    logic [IDX_W-1:0] index;
  } req_t;

  typedef struct packed {
    logic             ok;
    logic [IDX_W-1:0] found_index;
    logic [UID_W-1:0] uid_out;
    logic [CNT_W-1:0] entry_count;
  } res_t;

  typedef struct packed {
    logic start;
    logic out_free;
  } seq_ctl_t;

  typedef struct packed {
    logic idle;
    logic done;
  } seq_stat_t;

endpackage

FILE: sv/ualt_mem.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; used by the sequencer for the identifier table.
`timescale 1ns / 1ps
module ualt_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/ualt_seq.sv
// Request sequencer: fill count, the shared compare unit and the table RAM.
// Depends on ualt_pkg and ualt_mem.
`timescale 1ns / 1ps
module ualt_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  ualt_pkg::seq_ctl_t  ctl,
  input  ualt_pkg::req_t      req,
  output ualt_pkg::seq_stat_t stat,
  output ualt_pkg::res_t      res
);
  import ualt_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_MVRD = 3'd2;
  localparam logic [2:0] S_MVWR = 3'd3;
  localparam logic [2:0] S_RDRQ = 3'd4;
  localparam logic [2:0] S_RDGT = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] ptr_r, ptr_nxt;
  logic             chk_v_r, chk_v_nxt;
  logic [IDX_W-1:0] chk_idx_r, chk_idx_nxt;
  logic [ACT_W-1:0] act_r, act_nxt;
  logic [UID_W-1:0] key_r, key_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             ok_r, ok_nxt;
  logic [IDX_W-1:0] found_r, found_nxt;
  logic [UID_W-1:0] val_r, val_nxt;

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [UID_W-1:0] mem_wdata;
  logic [IDX_W-1:0] mem_raddr;
  logic [UID_W-1:0] mem_rdata;

  logic [CNT_W-1:0] last;
  logic             issue;
  logic             hit;
  logic             done;

  ualt_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (UID_W),
    .AW    (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign last  = cnt_r - CNT_W'(1);
  assign issue = (ptr_r < cnt_r);
  // The shared compare unit: one stored entry against the key each cycle.
  assign hit   = chk_v_r && (mem_rdata == key_r);

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    ptr_nxt     = ptr_r;
    chk_v_nxt   = 1'b0;
    chk_idx_nxt = chk_idx_r;
    act_nxt     = act_r;
    key_nxt     = key_r;
    idx_nxt     = idx_r;
    ok_nxt      = ok_r;
    found_nxt   = found_r;
    val_nxt     = val_r;
    mem_we      = 1'b0;
    mem_waddr   = idx_r;
    mem_wdata   = key_r;
    mem_raddr   = ptr_r[IDX_W-1:0];
    done        = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (ctl.start) begin
          act_nxt   = req.action;
          key_nxt   = req.uid;
          idx_nxt   = req.index;
          ok_nxt    = 1'b0;
          found_nxt = '0;
          val_nxt   = '0;
          ptr_nxt   = '0;
          case (req.action)
            ACT_SEARCH: begin
              state_nxt = S_SCAN;
            end
            ACT_ADD: begin
              state_nxt = (cnt_r == CNT_W'(CAPACITY)) ? S_FIN : S_SCAN;
            end
            ACT_DELETE: begin
              if (CNT_W'(req.index) < cnt_r) begin
                if (CNT_W'(req.index) == last) begin
                  cnt_nxt   = last;
                  ok_nxt    = 1'b1;
                  state_nxt = S_FIN;
                end else begin
                  state_nxt = S_MVRD;
                end
              end else begin
                state_nxt = S_FIN;
              end
            end
            ACT_READ: begin
              state_nxt = (CNT_W'(req.index) < cnt_r) ? S_RDRQ : S_FIN;
            end
            default: begin
              state_nxt = S_FIN;
            end
          endcase
        end
      end
      S_SCAN: begin
        chk_v_nxt   = issue;
        chk_idx_nxt = ptr_r[IDX_W-1:0];
        if (issue) begin
          ptr_nxt = ptr_r + CNT_W'(1);
        end
        if (hit) begin
          ok_nxt = 1'b1;
          if (act_r == ACT_SEARCH) begin
            found_nxt = chk_idx_r;
          end
          state_nxt = S_FIN;
        end else if (!issue) begin
          // Every entry below the count was compared without a match.
          if (act_r == ACT_ADD) begin
            mem_we    = 1'b1;
            mem_waddr = cnt_r[IDX_W-1:0];
            cnt_nxt   = cnt_r + CNT_W'(1);
            ok_nxt    = 1'b1;
          end
          state_nxt = S_FIN;
        end
      end
      S_MVRD: begin
        mem_raddr = last[IDX_W-1:0];
        state_nxt = S_MVWR;
      end
      S_MVWR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r;
        mem_wdata = mem_rdata;
        cnt_nxt   = last;
        ok_nxt    = 1'b1;
        state_nxt = S_FIN;
      end
      S_RDRQ: begin
        mem_raddr = idx_r;
        state_nxt = S_RDGT;
      end
      S_RDGT: begin
        val_nxt   = mem_rdata;
        ok_nxt    = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (ctl.out_free) begin
          done      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      chk_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      chk_v_r <= chk_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r     <= ptr_nxt;
    chk_idx_r <= chk_idx_nxt;
    act_r     <= act_nxt;
    key_r     <= key_nxt;
    idx_r     <= idx_nxt;
    ok_r      <= ok_nxt;
    found_r   <= found_nxt;
    val_r     <= val_nxt;
  end

  assign stat.idle       = (state_r == S_IDLE);
  assign stat.done       = done;
  assign res.ok          = ok_r;
  assign res.found_index = found_r;
  assign res.uid_out     = val_r;
  assign res.entry_count = cnt_r;

endmodule

FILE: sv/uid_access_list_table_core.sv
// Top level of the identifier access list table: input handshake, the
// request sequencer and the output register. Depends on ualt_pkg, ualt_seq.
//
//   channel   ports                                        direction
//   input     in_valid in_stall in_action in_uid in_index  request items in
//   result    out_valid out_stall out_ok out_found_index   result items out
//             out_uid_out out_entry_count
//
// A search or add walks the stored entries below the count at one entry per
// cycle through a single 32-bit comparator fed by the table RAM's registered
// read port. A delete moves the last entry into the freed slot and a read
// fetches one entry; a full-list add, an out-of-range delete or read, and a
// delete of the last entry go straight to the result without a RAM access.
// The block takes one item at a time: in_stall is high from acceptance until
// its result moves into the output register. A stalled result holds the
// output register, and the sequencer waits with the next result until it
// is taken.
// Reset (synchronous, rst_n low) empties the list by zeroing the fill count;
// the table contents need no clearing, since only entries below the count
// are ever read.
`timescale 1ns / 1ps
module uid_access_list_table_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [ualt_pkg::ACT_W-1:0]     in_action,
  input  logic [ualt_pkg::UID_W-1:0]     in_uid,
  input  logic [ualt_pkg::IDX_W-1:0]     in_index,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_ok,
  output logic [ualt_pkg::IDX_W-1:0]     out_found_index,
  output logic [ualt_pkg::UID_W-1:0]     out_uid_out,
  output logic [ualt_pkg::CNT_W-1:0]     out_entry_count
);
  import ualt_pkg::*;

  seq_ctl_t  ctl;
  seq_stat_t stat;
  req_t      req;
  res_t      res;

  logic out_valid_r, out_valid_nxt;
  res_t out_res_r;

  // The sequencer only takes a new request while it sits idle.
  assign in_stall = !stat.idle;

  assign req.action = in_action;
  assign req.uid    = in_uid;
  assign req.index  = in_index;

  assign ctl.start    = in_valid && !in_stall;
  // The output register can take a result when empty or being drained.
  assign ctl.out_free = !out_valid_r || !out_stall;

  ualt_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .req   (req),
    .stat  (stat),
    .res   (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (stat.done) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.done) begin
      out_res_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_ok          = out_res_r.ok;
  assign out_found_index = out_res_r.found_index;
  assign out_uid_out     = out_res_r.uid_out;
  assign out_entry_count = out_res_r.entry_count;

endmodule

FILE: sv/ualt_chk.sv
// Port-level checker for the identifier access list table, bound to the
// top level. Depends on ualt_pkg for widths and the capacity.
`timescale 1ns / 1ps
module ualt_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic                       out_ok,
  input logic [ualt_pkg::IDX_W-1:0] out_found_index,
  input logic [ualt_pkg::UID_W-1:0] out_uid_out,
  input logic [ualt_pkg::CNT_W-1:0] out_entry_count
);
  import ualt_pkg::*;

  // A result waiting on a stalled receiver stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result item dropped while stalled");

  // Every request moves the sequencer out of idle, so the block is busy
  // right after taking one.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted again in the cycle after an item");

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_entry_count <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  // A failed request carries no position and no identifier.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> out_found_index == '0 && out_uid_out == '0)
    else $error("failed request reports data");

  // Only a read carries an identifier, and a read reports no position.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_uid_out != '0 |-> out_found_index == '0)
    else $error("result reports both a position and an identifier");

endmodule

bind uid_access_list_table_core ualt_chk u_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_ok          (out_ok),
  .out_found_index (out_found_index),
  .out_uid_out     (out_uid_out),
  .out_entry_count (out_entry_count)
);
